/* rtl/u8dgs_pkg.sv */
package u8dgs_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned CELL_W  = 16;
    localparam int unsigned CNT_W   = 3;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;

    localparam logic [7:0]      QMARK      = 8'h3F;
    localparam logic [7:0]      DASH       = 8'h2D;
    localparam logic [7:0]      SPACE      = 8'h20;
    localparam logic [CP_W-1:0] CP_NBSP    = 21'h0000A0;
    localparam logic [CP_W-1:0] CP_EN_DASH = 21'h002013;
    localparam logic [CP_W-1:0] CP_EM_DASH = 21'h002014;
    localparam logic [CP_W-9:0] CP_CYR_HI  = 13'h0004;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [CP_W-1:0]   codepoint;
        logic              malformed;
        logic              glyph_bank;
        logic [7:0]        glyph_index;
        logic [CELL_W-1:0] cell_number;
        logic              run_last;
    } out_t;

    // One decoded byte: count cells, all '?' except possibly the last one.
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              last_good;
        logic [CP_W-1:0]   cp;
        logic [CELL_W-1:0] first_cell;
    } job_t;

endpackage

/* rtl/u8dgs_in_if.sv */
interface u8dgs_in_if;
    logic            valid;
    logic            ready;
    u8dgs_pkg::in_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/u8dgs_out_if.sv */
interface u8dgs_out_if;
    logic            valid;
    logic            ready;
    u8dgs_pkg::out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/utf8_decode_glyph_select_unit.sv */
// Lax UTF-8 decoder with glyph bank and index selection, one text byte per transfer.
// A byte with cells loads the emit counter; each cell is then registered in out_reg.
// Throughput: one byte per cycle unless stalled; a byte holds input until its last
// cell is out (one cell register, one cell out per cycle, up to four cells per byte).
// Reset: rst_n async low clears sequence state, cell count and valid flags.
module utf8_decode_glyph_select_unit (
    input  logic         clk,
    input  logic         rst_n,
    u8dgs_in_if.sink     text,
    u8dgs_out_if.source  cells
);

    logic              job_load;
    logic              job_ready;
    u8dgs_pkg::job_t   job;

    u8dgs_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .job_ready (job_ready),
        .job_load  (job_load),
        .job       (job)
    );

    u8dgs_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_load  (job_load),
        .job       (job),
        .job_ready (job_ready),
        .cells     (cells)
    );

endmodule

/* rtl/u8dgs_decode.sv */
module u8dgs_decode (
    input  logic               clk,
    input  logic               rst_n,
    u8dgs_in_if.sink           text,
    input  logic               job_ready,
    output logic               job_load,
    output u8dgs_pkg::job_t    job
);

    logic [7:0]                     pend0_reg, pend1_reg, pend2_reg;
    logic [1:0]                     exp_reg, exp_next;
    logic [1:0]                     rcv_reg, rcv_next;
    logic [u8dgs_pkg::CELL_W-1:0]   cell_reg, cell_next;

    logic [7:0]                     b;
    logic                           eot;
    logic                           accept;
    logic                           cont;
    logic [1:0]                     need;
    logic                           fresh_start;
    logic                           fresh_n;
    logic                           fresh_good;
    logic [u8dgs_pkg::CNT_W-1:0]    n;
    logic                           good;
    logic [u8dgs_pkg::CP_W-1:0]     cp;
    logic                           wr0, wr1, wr2;
    logic [u8dgs_pkg::CELL_W:0]     cell_sum;

    assign b           = text.data.text_byte;
    assign eot         = text.data.end_of_text;
    assign text.ready  = job_ready;
    assign accept      = text.valid && job_ready;
    assign cont        = (b[7:6] == 2'b10);

    always_comb
    begin
        if ((b & u8dgs_pkg::LEAD2_MASK) == u8dgs_pkg::LEAD2_VAL)
        begin
            need = 2'd1;
        end
        else if ((b & u8dgs_pkg::LEAD3_MASK) == u8dgs_pkg::LEAD3_VAL)
        begin
            need = 2'd2;
        end
        else if ((b & u8dgs_pkg::LEAD4_MASK) == u8dgs_pkg::LEAD4_VAL)
        begin
            need = 2'd3;
        end
        else
        begin
            need = 2'd0;
        end
        fresh_start = b[7] && (need != 2'd0) && !eot;
        fresh_n     = !fresh_start;
        fresh_good  = !b[7];
    end

    always_comb
    begin
        n        = '0;
        good     = 1'b0;
        cp       = {{(u8dgs_pkg::CP_W-8){1'b0}}, b};
        exp_next = exp_reg;
        rcv_next = rcv_reg;
        wr0      = 1'b0;
        wr1      = 1'b0;
        wr2      = 1'b0;
        if (exp_reg != 2'd0 && cont)
        begin
            if (({1'b0, rcv_reg} + 3'd1) >= {1'b0, exp_reg})
            begin
                n        = 3'd1;
                good     = 1'b1;
                exp_next = 2'd0;
                rcv_next = 2'd0;
                case (exp_reg)
                    2'd1:    cp = {10'd0, pend0_reg[4:0], b[5:0]};
                    2'd2:    cp = {5'd0, pend0_reg[3:0], pend1_reg[5:0], b[5:0]};
                    default: cp = {pend0_reg[2:0], pend1_reg[5:0], pend2_reg[5:0],
                                   b[5:0]};
                endcase
            end
            else
            begin
                wr1      = (rcv_reg == 2'd0);
                wr2      = (rcv_reg != 2'd0);
                rcv_next = rcv_reg + 2'd1;
                if (eot)
                begin
                    n        = {1'b0, rcv_reg} + 3'd2;
                    exp_next = 2'd0;
                    rcv_next = 2'd0;
                end
            end
        end
        else
        begin
            // Bad continuation or idle: any buffer flushes, byte starts over.
            if (exp_reg != 2'd0)
            begin
                n = {1'b0, rcv_reg} + 3'd1 + {2'b00, fresh_n};
            end
            else
            begin
                n = {2'b00, fresh_n};
            end
            good     = fresh_good;
            wr0      = fresh_start;
            exp_next = fresh_start ? need : 2'd0;
            rcv_next = 2'd0;
        end
    end

    assign cell_sum = {1'b0, cell_reg} + {{(u8dgs_pkg::CELL_W+1-u8dgs_pkg::CNT_W){1'b0}}, n};

    always_comb
    begin
        if (eot)
        begin
            cell_next = '0;
        end
        else if (cell_sum[u8dgs_pkg::CELL_W])
        begin
            cell_next = '1;
        end
        else
        begin
            cell_next = cell_sum[u8dgs_pkg::CELL_W-1:0];
        end
    end

    assign job_load       = accept && (n != '0);
    assign job.count      = n;
    assign job.last_good  = good;
    assign job.cp         = cp;
    assign job.first_cell = cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= '0;
            rcv_reg  <= '0;
            cell_reg <= '0;
        end
        else if (accept)
        begin
            exp_reg  <= exp_next;
            rcv_reg  <= rcv_next;
            cell_reg <= cell_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr0)
        begin
            pend0_reg <= b;
        end
        if (accept && wr1)
        begin
            pend1_reg <= b;
        end
        if (accept && wr2)
        begin
            pend2_reg <= b;
        end
    end

endmodule

/* rtl/u8dgs_emit.sv */
module u8dgs_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_load,
    input  u8dgs_pkg::job_t    job,
    output logic               job_ready,
    u8dgs_out_if.source        cells
);

    logic [u8dgs_pkg::CNT_W-1:0]   cnt_reg;
    logic                          good_reg;
    logic [u8dgs_pkg::CP_W-1:0]    cp_reg;
    logic [u8dgs_pkg::CELL_W-1:0]  cell_reg;

    logic                          out_valid_reg;
    u8dgs_pkg::out_t               out_reg;
    u8dgs_pkg::out_t               out_next;

    logic                          emit;
    logic                          is_last;
    logic                          good_now;

    assign is_last   = (cnt_reg == 3'd1);
    assign emit      = (cnt_reg != '0) && (!out_valid_reg || cells.ready);
    assign job_ready = (cnt_reg == '0) || (emit && is_last);
    assign good_now  = good_reg && is_last;

    always_comb
    begin
        out_next.codepoint   = cp_reg;
        out_next.malformed   = 1'b0;
        out_next.glyph_bank  = 1'b0;
        out_next.glyph_index = u8dgs_pkg::QMARK;
        out_next.cell_number = cell_reg;
        out_next.run_last    = is_last;
        if (!good_now)
        begin
            out_next.codepoint = {{(u8dgs_pkg::CP_W-8){1'b0}}, u8dgs_pkg::QMARK};
            out_next.malformed = 1'b1;
        end
        else if (cp_reg[u8dgs_pkg::CP_W-1:7] == '0)
        begin
            out_next.glyph_index = cp_reg[7:0];
        end
        else if (cp_reg[u8dgs_pkg::CP_W-1:8] == u8dgs_pkg::CP_CYR_HI)
        begin
            out_next.glyph_bank  = 1'b1;
            out_next.glyph_index = cp_reg[7:0];
        end
        else if (cp_reg == u8dgs_pkg::CP_EN_DASH || cp_reg == u8dgs_pkg::CP_EM_DASH)
        begin
            out_next.glyph_index = u8dgs_pkg::DASH;
        end
        else if (cp_reg == u8dgs_pkg::CP_NBSP)
        begin
            out_next.glyph_index = u8dgs_pkg::SPACE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_load)
            begin
                cnt_reg <= job.count;
            end
            else if (emit)
            begin
                cnt_reg <= cnt_reg - 3'd1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cells.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            good_reg <= job.last_good;
            cp_reg   <= job.cp;
            cell_reg <= job.first_cell;
        end
        else if (emit && cell_reg != '1)
        begin
            cell_reg <= cell_reg + 16'd1;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign cells.valid = out_valid_reg;
    assign cells.data  = out_reg;

endmodule
